// File: rtl/pds_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pds_pkg - shared types and helpers for the percent decoder
// Escape phase codes, the command word passed from the front to the back,
// and the hex digit decode.
// ---------------------------------------------------------------------------
package pds_pkg;

    // Default depth of the command queue between front and back
    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] PCT_CHAR = 8'h25;   // '%'

    // Escape phase, one-hot
    typedef enum logic [2:0] {
        PH_PLAIN = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } t_phase;

    // One queued command: a first result, and an optional second result
    typedef struct packed {
        logic       a_end;
        logic [7:0] a_byte;
        logic       b_valid;
        logic       b_end;
        logic [7:0] b_byte;
    } t_cmd;

    // Front to queue
    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_qwr;

    // Queue to back
    typedef struct packed {
        logic avail;
        t_cmd cmd;
    } t_qrd;

    // Hex digit decode result
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex r;
        r.ok  = 1'b0;
        r.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.ok  = 1'b1;
            r.val = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            // 'A'..'F' and 'a'..'f' both carry the digit in the low bits, offset by 9
            r.ok  = 1'b1;
            r.val = c[3:0] + 4'd9;
        end
        return r;
    endfunction

endpackage

// File: rtl/pds_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pds_if - stream channels of the percent decoder
// Input channel carries encoded bytes and the end flag, output channel
// carries decoded bytes and the end marker. Valid/ready handshake.
// ---------------------------------------------------------------------------
interface pds_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_text;

    modport source (output valid, output char_byte, output end_of_text, input ready);
    modport sink   (input valid, input char_byte, input end_of_text, output ready);
endinterface

interface pds_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_end;

    modport source (output valid, output out_byte, output out_end, input ready);
    modport sink   (input valid, input out_byte, input out_end, output ready);
endinterface

// File: rtl/percent_decode_stream.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// percent_decode_stream - streaming URL percent decoder
// Decodes %XX escapes in a byte stream, one input word per cycle while the command queue is not full.
// ---------------------------------------------------------------------------
// Usage:
//   i_in carries one byte of encoded text per word; a word with end_of_text
//   set closes the text (its char_byte is ignored). o_out carries decoded
//   bytes; the last word of each text has out_end set and out_byte zero.
//   A '%' plus two hex digits gives one byte; a broken escape drops the '%'
//   and passes the rest on (a held digit is sent as received).
// Output path: a word that yields output is pushed into the command queue
//   when accepted, then loaded from the queue head into the back end's
//   output register, from which o_out shows it.
// Throughput: one input word per cycle while the queue is not full. The back
//   end sends one output word per cycle while the receiver is ready; a word
//   with two results (broken escape after a digit) sends both in turn. The
//   P_FIFO_DEPTH-entry queue absorbs that; i_in.ready drops only when full.
// Reset: synchronous, active low; the queue empties, the decoder returns to
//   plain text and o_out.valid goes low.
// Receiver stall: o_out holds its word; input is still taken until the
//   queue is full.
// ---------------------------------------------------------------------------
module percent_decode_stream #(
    parameter int P_FIFO_DEPTH = pds_pkg::FIFO_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pds_in_if.sink    i_in,
    pds_out_if.source o_out
);
    import pds_pkg::*;

    t_qwr qwr;
    t_qrd qrd;
    logic full;
    logic pop;

    // Classification and escape tracking
    pds_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_qwr   (qwr)
    );

    // Command queue
    pds_fifo #(
        .P_DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qwr   (qwr),
        .o_full  (full),
        .i_pop   (pop),
        .o_qrd   (qrd)
    );

    // Result delivery
    pds_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qrd   (qrd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// File: rtl/pds_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pds_front - input side of the percent decoder
// Accepts one word per cycle while the queue is not full, tracks the escape phase and turns each word
// into zero, one or two results, pushed into the queue as one command.
// ---------------------------------------------------------------------------
module pds_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pds_in_if.sink        i_in,
    input  logic          i_full,
    output pds_pkg::t_qwr o_qwr
);
    import pds_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held,  n_held;
    logic       acc;
    t_hex       hx, hh;
    t_qwr       qwr;

    assign i_in.ready = !i_full;
    assign acc        = i_in.valid && i_in.ready;
    assign hx         = hex_decode(i_in.char_byte);
    assign hh         = hex_decode(r_held);

    // Classify the word against the current phase
    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        qwr     = '0;
        if (acc) begin
            if (i_in.end_of_text) begin
                // End counts as not hex: flush a held digit, then the marker
                qwr.push = 1'b1;
                n_phase  = PH_PLAIN;
                if (r_phase == PH_DIGIT) begin
                    qwr.cmd.a_byte  = r_held;
                    qwr.cmd.b_valid = 1'b1;
                    qwr.cmd.b_end   = 1'b1;
                end else begin
                    qwr.cmd.a_end = 1'b1;
                end
            end else begin
                unique case (r_phase)
                    PH_PCT: begin
                        if (hx.ok) begin
                            n_held  = i_in.char_byte;
                            n_phase = PH_DIGIT;
                        end else if (i_in.char_byte == PCT_CHAR) begin
                            n_phase = PH_PCT;
                        end else begin
                            qwr.push       = 1'b1;
                            qwr.cmd.a_byte = i_in.char_byte;
                            n_phase        = PH_PLAIN;
                        end
                    end
                    PH_DIGIT: begin
                        qwr.push = 1'b1;
                        if (hx.ok) begin
                            qwr.cmd.a_byte = {hh.val, hx.val};
                            n_phase        = PH_PLAIN;
                        end else begin
                            // Bad second digit: held digit goes out as received
                            qwr.cmd.a_byte = r_held;
                            if (i_in.char_byte == PCT_CHAR) begin
                                n_phase = PH_PCT;
                            end else begin
                                qwr.cmd.b_valid = 1'b1;
                                qwr.cmd.b_byte  = i_in.char_byte;
                                n_phase         = PH_PLAIN;
                            end
                        end
                    end
                    default: begin
                        if (i_in.char_byte == PCT_CHAR) begin
                            n_phase = PH_PCT;
                        end else begin
                            qwr.push       = 1'b1;
                            qwr.cmd.a_byte = i_in.char_byte;
                            n_phase        = PH_PLAIN;
                        end
                    end
                endcase
            end
        end
    end

    assign o_qwr = qwr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
        end else begin
            r_phase <= n_phase;
        end
    end

    // Held digit only read in the digit phase, no reset needed
    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

    // An end word always leaves the decoder in plain text
    a_end_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.end_of_text) |=> (r_phase == PH_PLAIN))
        else $error("phase not plain after end word");

endmodule

// File: rtl/pds_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pds_fifo - command queue between front and back
// Small register queue; head entry is visible while not empty.
// ---------------------------------------------------------------------------
module pds_fifo #(
    parameter int P_DEPTH = pds_pkg::FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pds_pkg::t_qwr i_qwr,
    output logic          o_full,
    input  logic          i_pop,
    output pds_pkg::t_qrd o_qrd
);
    import pds_pkg::*;

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    t_cmd            r_mem [P_DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;
    logic            push, pop;

    assign o_full      = (r_count == CW'(P_DEPTH));
    assign push        = i_qwr.push && !o_full;
    assign pop         = i_pop && (r_count != '0);
    assign o_qrd.avail = (r_count != '0);
    assign o_qrd.cmd   = r_mem[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == AW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_qwr.cmd;
        end
    end

    // The front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_qwr.push && o_full))
        else $error("push into full command queue");

    // The back never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && (r_count == '0)))
        else $error("pop from empty command queue");

    // Fill count stays in range
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(P_DEPTH))
        else $error("command queue count out of range");

endmodule

// File: rtl/pds_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pds_back - output side of the percent decoder
// Takes one command from the queue and delivers its one or two results,
// one output word per cycle, holding them while the receiver stalls.
// ---------------------------------------------------------------------------
module pds_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pds_pkg::t_qrd i_qrd,
    output logic          o_pop,
    pds_out_if.source     o_out
);
    import pds_pkg::*;

    t_cmd r_cur,    n_cur;
    logic r_busy,   n_busy;
    logic r_second, n_second;
    logic out_acc;
    logic last;

    assign out_acc        = o_out.valid && o_out.ready;
    assign last           = r_second || !r_cur.b_valid;
    assign o_pop          = i_qrd.avail && (!r_busy || (out_acc && last));

    assign o_out.valid    = r_busy;
    assign o_out.out_byte = r_second ? r_cur.b_byte : r_cur.a_byte;
    assign o_out.out_end  = r_second ? r_cur.b_end  : r_cur.a_end;

    // Step through the results of the current command, then load the next
    always_comb begin
        n_cur    = r_cur;
        n_busy   = r_busy;
        n_second = r_second;
        if (out_acc && !last) begin
            n_second = 1'b1;
        end else if (!r_busy || out_acc) begin
            n_second = 1'b0;
            n_busy   = i_qrd.avail;
            if (i_qrd.avail) begin
                n_cur = i_qrd.cmd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
    end

    // The second slot is only shown when the command has one
    a_second_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (r_busy && r_cur.b_valid))
        else $error("second result shown without one queued");

endmodule

// File: tb/percent_decode_stream_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// percent_decode_stream_test - self-checking bench for the percent decoder
// Drives encoded text words into the decoder with random gaps on both
// channels. An in-bench decoder model predicts every output word, and the
// output monitor compares each word against the oldest prediction.
// ---------------------------------------------------------------------------
module percent_decode_stream_test;

    import pds_pkg::*;

    localparam int DRAIN_CYCLES = 8;       // settle time past the last result
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       eot;
    } t_dec_word;

    logic i_clk;
    logic i_rst_n;

    pds_in_if  in_ch ();
    pds_out_if out_ch ();

    percent_decode_stream uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Decoder model state
    t_phase     dec_phase;
    logic [7:0] dec_held_digit;
    t_dec_word  pending_bytes[$];

    int src_idle_pct;
    int snk_idle_pct;
    int words_sent;
    int err_count;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---- decoder model ----------------------------------------------------

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        if (c <= "9") begin
            v = c - "0";
        end else if (c <= "F") begin
            v = c - "A" + 8'd10;
        end else begin
            v = c - "a" + 8'd10;
        end
        return v[3:0];
    endfunction

    // Byte seen outside an escape: '%' opens one, anything else passes
    function automatic void take_plain(input logic [7:0] c);
        if (c == PCT_CHAR) begin
            dec_phase = PH_PCT;
        end else begin
            dec_phase = PH_PLAIN;
            pending_bytes.push_back('{data: c, eot: 1'b0});
        end
    endfunction

    function automatic void predict_decode(input logic [7:0] c, input logic eot);
        if (eot) begin
            // end of text counts as not hex: pending '%' dropped, held digit flushed
            if (dec_phase == PH_DIGIT)
                pending_bytes.push_back('{data: dec_held_digit, eot: 1'b0});
            dec_phase = PH_PLAIN;
            pending_bytes.push_back('{data: 8'h00, eot: 1'b1});
            return;
        end
        case (dec_phase)
            PH_PCT: begin
                if (is_hex(c)) begin
                    dec_held_digit = c;
                    dec_phase      = PH_DIGIT;
                end else begin
                    take_plain(c);
                end
            end
            PH_DIGIT: begin
                if (is_hex(c)) begin
                    pending_bytes.push_back('{data: {hex_nibble(dec_held_digit), hex_nibble(c)},
                                              eot: 1'b0});
                    dec_phase = PH_PLAIN;
                end else begin
                    // broken escape: held digit goes out as received
                    pending_bytes.push_back('{data: dec_held_digit, eot: 1'b0});
                    take_plain(c);
                end
            end
            default: take_plain(c);
        endcase
    endfunction

    // ---- stimulus helpers -------------------------------------------------

    function automatic logic [7:0] hex_char(input int v, input bit upper);
        if (v < 10)
            return 8'("0") + 8'(v);
        return (upper ? 8'("A") : 8'("a")) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (is_hex(c));
        return c;
    endfunction

    function automatic logic [7:0] rand_hex_char();
        return hex_char(int'($urandom_range(15)), $urandom_range(1) == 1);
    endfunction

    // Send one word; returns at the edge where it is taken, valid still high
    task automatic send_word(input logic [7:0] c, input logic eot);
        if ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_ch.char_byte   <= c;
        in_ch.end_of_text <= eot;
        in_ch.valid       <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_decode(c, eot);
        words_sent++;
    endtask

    // Hold off input until every predicted word has come out
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---- output monitor ---------------------------------------------------

    always @(posedge i_clk) begin
        t_dec_word want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_bytes.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("ERROR: unexpected word byte=%02h end=%0b",
                                 out_ch.out_byte, out_ch.out_end);
                end else begin
                    want = pending_bytes.pop_front();
                    if (out_ch.out_byte !== want.data || out_ch.out_end !== want.eot) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("ERROR: expected byte=%02h end=%0b, got byte=%02h end=%0b",
                                     want.data, want.eot, out_ch.out_byte, out_ch.out_end);
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // ---- tests ------------------------------------------------------------

    // Extremes of the byte range pass untouched; end word payload is ignored
    task automatic test_plain_bytes();
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h5A, 1'b1);
    endtask

    // Well-formed escapes, both digit cases, lowest and highest value
    task automatic test_valid_escapes();
        send_word(PCT_CHAR, 1'b0);
        send_word("0", 1'b0);
        send_word("0", 1'b0);
        send_word(PCT_CHAR, 1'b0);
        send_word("f", 1'b0);
        send_word("F", 1'b0);
    endtask

    // Broken escapes: '%' restarts, bad byte after a digit, '%' after a digit
    task automatic test_broken_escapes();
        send_word(PCT_CHAR, 1'b0);
        send_word(PCT_CHAR, 1'b0);
        send_word("4", 1'b0);
        send_word("1", 1'b0);
        send_word(PCT_CHAR, 1'b0);
        send_word("5", 1'b0);
        send_word("Z", 1'b0);
        send_word(PCT_CHAR, 1'b0);
        send_word("b", 1'b0);
        send_word(PCT_CHAR, 1'b0);
        send_word("3", 1'b0);
        send_word("c", 1'b0);
    endtask

    // Text ends with a '%' pending, then with a digit held
    task automatic test_end_in_escape();
        send_word(PCT_CHAR, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(PCT_CHAR, 1'b0);
        send_word("7", 1'b0);
        send_word(8'h00, 1'b1);
    endtask

    // Mostly well-formed texts with random content, some raw noise
    task automatic test_random_texts(input int n_words);
        int  start;
        int  len;
        int  kind;
        bit  paused;
        logic [7:0] c;
        start  = words_sent;
        paused = 1'b0;
        while (words_sent - start < n_words) begin
            if (!paused && words_sent - start >= n_words / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(9) == 0) begin
                // noise: any byte, '%' often, a stray end now and then
                c = ($urandom_range(3) == 0) ? PCT_CHAR : 8'($urandom_range(255));
                send_word(c, $urandom_range(15) == 0);
            end else begin
                len = $urandom_range(1, 8);
                for (int t = 0; t < len; t++) begin
                    kind = $urandom_range(99);
                    if (kind < 45) begin
                        do c = 8'($urandom_range(255)); while (c == PCT_CHAR);
                        send_word(c, 1'b0);
                    end else if (kind < 80) begin
                        send_word(PCT_CHAR, 1'b0);
                        send_word(rand_hex_char(), 1'b0);
                        send_word(rand_hex_char(), 1'b0);
                    end else if (kind < 90) begin
                        send_word(PCT_CHAR, 1'b0);
                        send_word(($urandom_range(3) == 0) ? PCT_CHAR : non_hex_char(), 1'b0);
                    end else begin
                        send_word(PCT_CHAR, 1'b0);
                        send_word(rand_hex_char(), 1'b0);
                        send_word(($urandom_range(3) == 0) ? PCT_CHAR : non_hex_char(), 1'b0);
                    end
                end
                // sometimes close the text inside an escape
                kind = $urandom_range(9);
                if (kind == 0) begin
                    send_word(PCT_CHAR, 1'b0);
                end else if (kind == 1) begin
                    send_word(PCT_CHAR, 1'b0);
                    send_word(rand_hex_char(), 1'b0);
                end
                send_word(8'($urandom_range(255)), 1'b1);
            end
        end
    endtask

    // ---- main sequence ----------------------------------------------------

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.char_byte   = 8'h00;
        in_ch.end_of_text = 1'b0;
        out_ch.ready      = 1'b0;
        dec_phase         = PH_PLAIN;
        dec_held_digit    = 8'h00;
        words_sent        = 0;
        err_count         = 0;
        src_idle_pct      = 9;
        snk_idle_pct      = 73;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_plain_bytes();
        test_valid_escapes();
        test_broken_escapes();
        test_end_in_escape();
        wait_drained();

        test_random_texts(175);
        wait_drained();

        src_idle_pct = 73;
        snk_idle_pct = 9;
        test_random_texts(175);
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_texts(175);
        wait_drained();

        if (err_count == 0 && pending_bytes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Run limit
    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: percent_decode_stream.f
rtl/pds_pkg.sv
rtl/pds_if.sv
rtl/pds_front.sv
rtl/pds_fifo.sv
rtl/pds_back.sv
rtl/percent_decode_stream.sv
tb/percent_decode_stream_test.sv
